// ----- rtl/pwrop_pkg.sv -----
// shared types, codes and constants of the pixel write raster op unit
`timescale 1ns / 1ps

package pwrop_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned BIT_ADDR_W = 32;
    localparam int unsigned BYTE_ADDR_W = 29;
    localparam int unsigned SHIFT_W    = 4;
    localparam int unsigned SIZE_W     = 3;
    localparam int unsigned ROP_W      = 5;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENCY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_OP    = 2'd2;

    // pixel size codes
    localparam logic [SIZE_W-1:0] PSIZE_1  = 3'd0;
    localparam logic [SIZE_W-1:0] PSIZE_2  = 3'd1;
    localparam logic [SIZE_W-1:0] PSIZE_4  = 3'd2;
    localparam logic [SIZE_W-1:0] PSIZE_8  = 3'd3;
    localparam logic [SIZE_W-1:0] PSIZE_16 = 3'd4;

    // raster op codes
    localparam logic [ROP_W-1:0] ROP_AND       = 5'd1;
    localparam logic [ROP_W-1:0] ROP_AND_NOTD  = 5'd2;
    localparam logic [ROP_W-1:0] ROP_ZERO      = 5'd3;
    localparam logic [ROP_W-1:0] ROP_OR_NOTD   = 5'd4;
    localparam logic [ROP_W-1:0] ROP_XNOR      = 5'd5;
    localparam logic [ROP_W-1:0] ROP_NOTD      = 5'd6;
    localparam logic [ROP_W-1:0] ROP_NOR       = 5'd7;
    localparam logic [ROP_W-1:0] ROP_OR        = 5'd8;
    localparam logic [ROP_W-1:0] ROP_DEST      = 5'd9;
    localparam logic [ROP_W-1:0] ROP_XOR       = 5'd10;
    localparam logic [ROP_W-1:0] ROP_NOTS_AND  = 5'd11;
    localparam logic [ROP_W-1:0] ROP_ONES      = 5'd12;
    localparam logic [ROP_W-1:0] ROP_NOTS_OR   = 5'd13;
    localparam logic [ROP_W-1:0] ROP_NAND      = 5'd14;
    localparam logic [ROP_W-1:0] ROP_NOTS      = 5'd15;
    localparam logic [ROP_W-1:0] ROP_ADD       = 5'd16;
    localparam logic [ROP_W-1:0] ROP_ADD_SAT   = 5'd17;
    localparam logic [ROP_W-1:0] ROP_SUB       = 5'd18;
    localparam logic [ROP_W-1:0] ROP_SUB_SAT   = 5'd19;
    localparam logic [ROP_W-1:0] ROP_MAX       = 5'd20;
    localparam logic [ROP_W-1:0] ROP_MIN       = 5'd21;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [BIT_ADDR_W-1:0] bit_address;
        logic [WORD_W-1:0]     pixel_value;
        logic [WORD_W-1:0]     memory_word;
    } pix_in_t;

    typedef struct packed {
        logic                   mem_write_enable;
        logic [BYTE_ADDR_W-1:0] mem_byte_address;
        logic [WORD_W-1:0]      mem_write_data;
        logic                   word_boundary;
        logic [WORD_W-1:0]      pixel_read_value;
    } pix_out_t;

endpackage

// ----- rtl/pwrop_alu.sv -----
// raster op unit: logic and arithmetic ops on source and destination pixels
`timescale 1ns / 1ps

module pwrop_alu
    import pwrop_pkg::*;
(
    input  logic [ROP_W-1:0]  op,
    input  logic [WORD_W-1:0] src,
    input  logic [WORD_W-1:0] dst,
    input  logic [WORD_W-1:0] mask,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] d;
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] diff;
    logic              d_gt_s;
    logic [WORD_W-1:0] raw;

    assign s      = src & mask;
    assign d      = dst & mask;
    assign sum    = {1'b0, s} + {1'b0, d};
    assign diff   = d - s;
    assign d_gt_s = d > s;

    always_comb begin
        unique case (op)
            ROP_AND:      raw = s & d;
            ROP_AND_NOTD: raw = s & ~d;
            ROP_ZERO:     raw = '0;
            ROP_OR_NOTD:  raw = s | ~d;
            ROP_XNOR:     raw = ~(s ^ d);
            ROP_NOTD:     raw = ~d;
            ROP_NOR:      raw = ~(s | d);
            ROP_OR:       raw = s | d;
            ROP_DEST:     raw = d;
            ROP_XOR:      raw = s ^ d;
            ROP_NOTS_AND: raw = ~s & d;
            ROP_ONES:     raw = '1;
            ROP_NOTS_OR:  raw = ~s | d;
            ROP_NAND:     raw = ~(s & d);
            ROP_NOTS:     raw = ~s;
            ROP_ADD:      raw = sum[WORD_W-1:0];
            ROP_ADD_SAT:  raw = (sum > {1'b0, mask}) ? mask : sum[WORD_W-1:0];
            ROP_SUB:      raw = diff;
            ROP_SUB_SAT:  raw = d_gt_s ? diff : '0;
            ROP_MAX:      raw = d_gt_s ? d : s;
            ROP_MIN:      raw = d_gt_s ? s : d;
            default:      raw = s;
        endcase
    end

    assign result = raw & mask;

endmodule

// ----- rtl/pixel_write_raster_op_unit_core.sv -----
// top level of the pixel write raster op unit with one cached frame word
`timescale 1ns / 1ps
// two register stages (input register, result register); an accepted word is held in the
// input register and then in the result register, which drives m_valid
// throughput: one word per cycle while m_ready holds; the cache compare, merge and raster op
// sit in one stage; while a result waits, one more word is taken only if the input register is empty
// reset (aresetn low, synchronous): configuration registers 0, cache invalid, both pipeline stages empty

module pixel_write_raster_op_unit_core
    import pwrop_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pix_in_t               s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output pix_out_t              m_data,
    // configuration writes
    input  logic                  cfg_write_enable,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [SIZE_W-1:0] pixel_size_reg;
    logic              transparency_reg;
    logic [ROP_W-1:0]  raster_op_reg;

    // input stage
    logic    in_valid_reg;
    pix_in_t in_data_reg;

    // result stage
    logic     out_valid_reg;
    pix_out_t out_data_reg;

    // cached frame word
    logic [BYTE_ADDR_W-1:0] cache_addr_reg;
    logic                   cache_valid_reg;
    logic [WORD_W-1:0]      cache_word_reg;
    logic                   cache_changed_reg;

    logic [BYTE_ADDR_W-1:0] cache_addr_next;
    logic                   cache_valid_next;
    logic [WORD_W-1:0]      cache_word_next;
    logic                   cache_changed_next;
    pix_out_t               out_data_next;

    // handshake
    logic advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration write port, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_size_reg   <= PSIZE_1;
            transparency_reg <= 1'b0;
            raster_op_reg    <= '0;
        end else if (cfg_write_enable) begin
            unique case (cfg_index)
                CFG_PIXEL_SIZE:   pixel_size_reg   <= cfg_data[SIZE_W-1:0];
                CFG_TRANSPARENCY: transparency_reg <= cfg_data[0];
                CFG_RASTER_OP:    raster_op_reg    <= cfg_data[ROP_W-1:0];
                default: ;
            endcase
        end
    end

    // pixel geometry: mask at pixel width and shift inside the word
    logic [WORD_W-1:0]      pix_mask;
    logic [SHIFT_W-1:0]     align_mask;
    logic                   wide_pixel;
    logic [SHIFT_W-1:0]     pix_shift;
    logic [BYTE_ADDR_W-1:0] word_addr;

    always_comb begin
        // codes above 16-bit fall back to 1-bit pixels
        unique case (pixel_size_reg)
            PSIZE_2: begin
                pix_mask = 16'h0003; align_mask = 4'he;
            end
            PSIZE_4: begin
                pix_mask = 16'h000f; align_mask = 4'hc;
            end
            PSIZE_8: begin
                pix_mask = 16'h00ff; align_mask = 4'h8;
            end
            PSIZE_16: begin
                pix_mask = 16'hffff; align_mask = 4'h0;
            end
            default: begin
                pix_mask = 16'h0001; align_mask = 4'hf;
            end
        endcase
    end

    assign wide_pixel = (pixel_size_reg == PSIZE_16);
    assign pix_shift  = in_data_reg.bit_address[SHIFT_W-1:0] & align_mask;
    // byte address of the word: bit address over 16, times 2
    assign word_addr  = {in_data_reg.bit_address[BIT_ADDR_W-1:SHIFT_W], 1'b0};

    // cache lookup and destination pixel
    logic              cache_miss;
    logic [WORD_W-1:0] base_word;
    logic [WORD_W-1:0] old_pix;
    logic [WORD_W-1:0] alu_dst;
    logic [WORD_W-1:0] rop_result;
    logic              pix_written;
    logic [WORD_W-1:0] merged_word;

    assign cache_miss  = !cache_valid_reg || (cache_addr_reg != word_addr);
    assign base_word   = cache_miss ? in_data_reg.memory_word : cache_word_reg;
    assign old_pix     = (base_word >> pix_shift) & pix_mask;
    // 16-bit pixels take the memory word as destination, no cache involved
    assign alu_dst     = wide_pixel ? in_data_reg.memory_word : old_pix;
    // transparency drops zero results
    assign pix_written = !transparency_reg || (rop_result != '0);
    assign merged_word = (base_word & ~(pix_mask << pix_shift)) | (rop_result << pix_shift);

    pwrop_alu u_alu (
        .op     (raster_op_reg),
        .src    (in_data_reg.pixel_value),
        .dst    (alu_dst),
        .mask   (pix_mask),
        .result (rop_result)
    );

    // result word and cache update for the word in the input stage
    always_comb begin
        out_data_next      = '0;
        cache_addr_next    = cache_addr_reg;
        cache_valid_next   = cache_valid_reg;
        cache_word_next    = cache_word_reg;
        cache_changed_next = cache_changed_reg;

        unique case (in_data_reg.kind)
            KIND_READ: begin
                out_data_next.pixel_read_value =
                    (in_data_reg.memory_word >> pix_shift) & pix_mask;
            end
            KIND_FLUSH: begin
                // flush writes back any valid word, changed or not
                if (cache_valid_reg) begin
                    out_data_next.mem_write_enable = 1'b1;
                    out_data_next.mem_byte_address = cache_addr_reg;
                    out_data_next.mem_write_data   = cache_word_reg;
                end
                cache_valid_next   = 1'b0;
                cache_changed_next = 1'b0;
            end
            KIND_WRITE: begin
                if (wide_pixel) begin
                    // straight to memory
                    out_data_next.word_boundary = 1'b1;
                    if (pix_written) begin
                        out_data_next.mem_write_enable = 1'b1;
                        out_data_next.mem_byte_address = word_addr;
                        out_data_next.mem_write_data   = rop_result;
                    end
                end else begin
                    if (cache_miss && cache_valid_reg) begin
                        // leaving the cached word: write back, in transparent mode only if dirty
                        out_data_next.word_boundary = 1'b1;
                        if (!transparency_reg || cache_changed_reg) begin
                            out_data_next.mem_write_enable = 1'b1;
                            out_data_next.mem_byte_address = cache_addr_reg;
                            out_data_next.mem_write_data   = cache_word_reg;
                        end
                    end
                    cache_addr_next  = word_addr;
                    cache_valid_next = 1'b1;
                    if (pix_written) begin
                        cache_word_next    = merged_word;
                        cache_changed_next = 1'b1;
                    end else begin
                        cache_word_next    = base_word;
                        cache_changed_next = cache_miss ? 1'b0 : cache_changed_reg;
                    end
                end
            end
            default: ; // unused kind: zero result, state untouched
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // cache state, committed as the word leaves the input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_addr_reg    <= '0;
            cache_valid_reg   <= 1'b0;
            cache_word_reg    <= '0;
            cache_changed_reg <= 1'b0;
        end else if (advance) begin
            cache_addr_reg    <= cache_addr_next;
            cache_valid_reg   <= cache_valid_next;
            cache_word_reg    <= cache_word_next;
            cache_changed_reg <= cache_changed_next;
        end
    end

endmodule
